### design/battery_current_limit_derating_defines.svh
// ----------------------------------------------------------------------------
// Battery current limit derating: assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CURRENT_LIMIT_DERATING_DEFINES_SVH
`define BATTERY_CURRENT_LIMIT_DERATING_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while reset is released.
`define BCLD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BCLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BCLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/bcld_pkg.sv
// ----------------------------------------------------------------------------
// Battery current limit derating: package
// Beat types, breakpoint tables and the segment lookup helpers.
// ----------------------------------------------------------------------------
package bcld_pkg;

    localparam int CAP_W   = 20;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 23;
    localparam int X_W     = 18;   // common signed domain for all table inputs
    localparam int SEG_W   = 4;
    localparam int FR_W    = 14;   // offset into a segment, up to its width
    localparam int Y_W     = 9;    // table values and slope magnitudes
    localparam int M_W     = 17;   // |dy| * offset, below 2^17 for these tables
    localparam int RCP_W   = 26;
    localparam int RCP_SH  = 31;
    localparam int C_W     = 11;   // signed interpolated limit
    localparam int PROD_W  = 29;   // limit * capacity
    localparam int D100_W  = 30;
    localparam int D100_SH = 36;
    localparam logic [D100_W-1:0] D100_RCP = 30'd687194768;  // ceil(2^36 / 100)
    localparam logic [CAP_W-1:0]  CAP_RESET = 20'd50000;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int NUM_TBL = 6;
    localparam int PTS_MAX = 15;

    // Lane order: charge limits first, then discharge limits.
    localparam int TBL_TEMP_CHG = 0;
    localparam int TBL_SOC_CHG  = 1;
    localparam int TBL_CELL_CHG = 2;
    localparam int TBL_TEMP_DIS = 3;
    localparam int TBL_SOC_DIS  = 4;
    localparam int TBL_CELL_DIS = 5;

    // Short tables are padded with their last point, which never counts as a
    // breakpoint below the clamped input.
    localparam int TBL_X [NUM_TBL][PTS_MAX] = '{
        '{-250, 0, 50, 150, 350, 450, 550, 650, 650, 650, 650, 650, 650, 650, 650},
        '{0, 8500, 9000, 9500, 10000, 10000, 10000, 10000, 10000, 10000, 10000,
          10000, 10000, 10000, 10000},
        '{3000, 4100, 4200, 4200, 4200, 4200, 4200, 4200, 4200, 4200, 4200, 4200,
          4200, 4200, 4200},
        '{-250, -150, -100, -50, 0, 50, 100, 250, 300, 350, 450, 550, 600, 650, 700},
        '{0, 200, 500, 800, 1000, 1500, 2000, 5000, 10000, 10000, 10000, 10000,
          10000, 10000, 10000},
        '{3000, 3200, 3300, 3400, 3450, 3550, 4200, 4200, 4200, 4200, 4200, 4200,
          4200, 4200, 4200}
    };

    localparam int TBL_Y [NUM_TBL][PTS_MAX] = '{
        '{0, 0, 0, 300, 300, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{300, 300, 200, 100, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50},
        '{300, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{20, 20, 100, 150, 200, 450, 500, 500, 450, 400, 380, 380, 20, 20, 0},
        '{100, 100, 220, 220, 400, 400, 500, 500, 500, 500, 500, 500, 500, 500, 500},
        '{0, 0, 200, 250, 380, 500, 500, 500, 500, 500, 500, 500, 500, 500, 500}
    };

    typedef struct packed {
        logic signed [IN_W-1:0] max_temp;
        logic [IN_W-1:0]        charge_level;
        logic [IN_W-1:0]        high_cell_mv;
        logic [IN_W-1:0]        low_cell_mv;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] charge_limit_ma;
        logic [OUT_W-1:0] discharge_limit_ma;
    } t_out_item;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [FR_W-1:0]  fr;
    } t_seg;

    typedef struct packed {
        t_seg [NUM_TBL-1:0] lane;
    } t_class_item;

    typedef struct packed {
        logic [Y_W-1:0]   y0;
        logic             dy_neg;
        logic [Y_W-1:0]   dy_mag;
        logic [RCP_W-1:0] rcp;
    } t_coef;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_q_stat;

    // ceil(2^31 / dx) for every segment width in the tables. With products
    // below 2^17 the high bits of product * reciprocal are the exact floor.
    function automatic logic [RCP_W-1:0] recip_of(input int dx);
        logic [RCP_W-1:0] r;
        unique case (dx)
            50:      r = 26'd42949673;
            100:     r = 26'd21474837;
            150:     r = 26'd14316558;
            200:     r = 26'd10737419;
            250:     r = 26'd8589935;
            300:     r = 26'd7158279;
            500:     r = 26'd4294968;
            650:     r = 26'd3303821;
            1100:    r = 26'd1952258;
            3000:    r = 26'd715828;
            5000:    r = 26'd429497;
            8500:    r = 26'd252646;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Clamp to the table ends, then pick the segment and the offset into it.
    // The bottom clamp lands at the start of the first segment and the top
    // clamp at the end of the last one, so no clamp flag is needed.
    function automatic t_seg classify(input int tbl, input logic signed [X_W-1:0] x);
        logic signed [X_W-1:0] lo;
        logic signed [X_W-1:0] hi;
        logic signed [X_W-1:0] xc;
        logic signed [X_W-1:0] base;
        logic [SEG_W-1:0]      cnt;
        t_seg                  s;
        lo = X_W'(TBL_X[tbl][0]);
        hi = X_W'(TBL_X[tbl][PTS_MAX-1]);
        if (x < lo) begin
            xc = lo;
        end else if (x > hi) begin
            xc = hi;
        end else begin
            xc = x;
        end
        cnt = '0;
        for (int j = 0; j < PTS_MAX; j++) begin
            if (X_W'(TBL_X[tbl][j]) < xc) begin
                cnt = cnt + 4'd1;
            end
        end
        if (cnt == '0) begin
            cnt = 4'd1;
        end
        base  = X_W'(TBL_X[tbl][cnt - 4'd1]);
        s.seg = cnt;
        s.fr  = FR_W'(xc - base);
        return s;
    endfunction

    function automatic t_coef seg_coef(input int tbl, input logic [SEG_W-1:0] seg);
        int    x0;
        int    x1;
        int    y0;
        int    dy;
        t_coef c;
        x0       = TBL_X[tbl][seg - 4'd1];
        x1       = TBL_X[tbl][seg];
        y0       = TBL_Y[tbl][seg - 4'd1];
        dy       = TBL_Y[tbl][seg] - y0;
        c.y0     = Y_W'(y0);
        c.dy_neg = (dy < 0);
        c.dy_mag = Y_W'((dy < 0) ? -dy : dy);
        c.rcp    = recip_of(x1 - x0);
        return c;
    endfunction

endpackage

### design/bcld_front.sv
// ----------------------------------------------------------------------------
// Battery current limit derating: front end
// Takes input beats and finds the segment and offset in all six tables.
// ----------------------------------------------------------------------------
module bcld_front import bcld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_wr_valid,
    input  logic        i_wr_ready,
    output t_class_item o_wr_data
);

    logic signed [X_W-1:0] temp_x;
    logic signed [X_W-1:0] soc_x;
    logic signed [X_W-1:0] hcell_x;
    logic signed [X_W-1:0] lcell_x;
    logic                  r_busy;

    // Temperature is signed; the other fields are zero extended.
    assign temp_x  = X_W'(i_in_data.max_temp);
    assign soc_x   = {2'b00, i_in_data.charge_level};
    assign hcell_x = {2'b00, i_in_data.high_cell_mv};
    assign lcell_x = {2'b00, i_in_data.low_cell_mv};

    always_comb begin
        o_wr_data.lane[TBL_TEMP_CHG] = classify(TBL_TEMP_CHG, temp_x);
        o_wr_data.lane[TBL_SOC_CHG]  = classify(TBL_SOC_CHG, soc_x);
        o_wr_data.lane[TBL_CELL_CHG] = classify(TBL_CELL_CHG, hcell_x);
        o_wr_data.lane[TBL_TEMP_DIS] = classify(TBL_TEMP_DIS, temp_x);
        o_wr_data.lane[TBL_SOC_DIS]  = classify(TBL_SOC_DIS, soc_x);
        o_wr_data.lane[TBL_CELL_DIS] = classify(TBL_CELL_DIS, lcell_x);
    end

    // Hold off intake for the cycle of reset release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_wr_valid = i_in_valid && !r_busy;
    assign o_in_ready = i_wr_ready && !r_busy;

endmodule

### design/bcld_queue.sv
// ----------------------------------------------------------------------------
// Battery current limit derating: decoupling queue
// Small FIFO of classified beats between the front end and the back end.
// ----------------------------------------------------------------------------
module bcld_queue import bcld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_valid,
    output logic        o_wr_ready,
    input  t_class_item i_wr_data,
    output logic        o_rd_valid,
    input  logic        i_rd_ready,
    output t_class_item o_rd_data,
    output t_q_stat     o_stat
);

    t_class_item      r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_wr_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign o_stat     = '{count: r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### design/bcld_back.sv
// ----------------------------------------------------------------------------
// Battery current limit derating: back end
// Five-stage pipeline: slope product, exact divide, minimum, scale, /100.
// ----------------------------------------------------------------------------
module bcld_back import bcld_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_valid,
    output logic             o_rd_ready,
    input  t_class_item      i_rd_data,
    input  logic [CAP_W-1:0] i_capacity,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    t_coef                 coef [NUM_TBL];
    logic [Y_W+FR_W-1:0]   dyfr [NUM_TBL];
    logic [M_W+RCP_W-1:0]  mr   [NUM_TBL];
    logic signed [C_W-1:0] lim  [NUM_TBL];
    logic signed [C_W-1:0] min_chg;
    logic signed [C_W-1:0] min_dis;
    logic [PROD_W+D100_W-1:0] div_chg;
    logic [PROD_W+D100_W-1:0] div_dis;

    logic [M_W-1:0]    r_s1_m   [NUM_TBL];
    logic              r_s1_neg [NUM_TBL];
    logic [Y_W-1:0]    r_s1_y0  [NUM_TBL];
    logic [RCP_W-1:0]  r_s1_rcp [NUM_TBL];
    logic [Y_W-1:0]    r_s2_q   [NUM_TBL];
    logic              r_s2_neg [NUM_TBL];
    logic [Y_W-1:0]    r_s2_y0  [NUM_TBL];
    logic [Y_W-1:0]    r_s3_chg;
    logic [Y_W-1:0]    r_s3_dis;
    logic [PROD_W-1:0] r_s4_chg;
    logic [PROD_W-1:0] r_s4_dis;
    t_out_item         r_s5;

    assign rdy5       = !r_v5 || i_out_ready;
    assign rdy4       = !r_v4 || rdy5;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_rd_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_rd_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Stage 1: segment constants and |dy| * offset per lane.
    always_comb begin
        for (int k = 0; k < NUM_TBL; k++) begin
            coef[k] = seg_coef(k, i_rd_data.lane[k].seg);
            dyfr[k] = coef[k].dy_mag * i_rd_data.lane[k].fr;
        end
    end

    // Stage 2: exact floor division by the segment width.
    always_comb begin
        for (int k = 0; k < NUM_TBL; k++) begin
            mr[k] = r_s1_m[k] * r_s1_rcp[k];
        end
    end

    // Stage 3: apply the slope sign, then take each side's minimum.
    always_comb begin
        for (int k = 0; k < NUM_TBL; k++) begin
            if (r_s2_neg[k]) begin
                lim[k] = $signed({2'b00, r_s2_y0[k]}) - $signed({2'b00, r_s2_q[k]});
            end else begin
                lim[k] = $signed({2'b00, r_s2_y0[k]}) + $signed({2'b00, r_s2_q[k]});
            end
        end
        min_chg = lim[TBL_TEMP_CHG];
        if (lim[TBL_SOC_CHG] < min_chg) min_chg = lim[TBL_SOC_CHG];
        if (lim[TBL_CELL_CHG] < min_chg) min_chg = lim[TBL_CELL_CHG];
        min_dis = lim[TBL_TEMP_DIS];
        if (lim[TBL_SOC_DIS] < min_dis) min_dis = lim[TBL_SOC_DIS];
        if (lim[TBL_CELL_DIS] < min_dis) min_dis = lim[TBL_CELL_DIS];
    end

    // Stage 5: divide by 100 through its reciprocal.
    assign div_chg = r_s4_chg * D100_RCP;
    assign div_dis = r_s4_dis * D100_RCP;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_rd_valid) begin
            for (int k = 0; k < NUM_TBL; k++) begin
                r_s1_m[k]   <= dyfr[k][M_W-1:0];
                r_s1_neg[k] <= coef[k].dy_neg;
                r_s1_y0[k]  <= coef[k].y0;
                r_s1_rcp[k] <= coef[k].rcp;
            end
        end
        if (rdy2 && r_v1) begin
            for (int k = 0; k < NUM_TBL; k++) begin
                r_s2_q[k]   <= mr[k][RCP_SH +: Y_W];
                r_s2_neg[k] <= r_s1_neg[k];
                r_s2_y0[k]  <= r_s1_y0[k];
            end
        end
        if (rdy3 && r_v2) begin
            r_s3_chg <= (min_chg < 0) ? '0 : min_chg[Y_W-1:0];
            r_s3_dis <= (min_dis < 0) ? '0 : min_dis[Y_W-1:0];
        end
        if (rdy4 && r_v3) begin
            r_s4_chg <= r_s3_chg * i_capacity;
            r_s4_dis <= r_s3_dis * i_capacity;
        end
        if (rdy5 && r_v4) begin
            r_s5.charge_limit_ma    <= div_chg[D100_SH +: OUT_W];
            r_s5.discharge_limit_ma <= div_dis[D100_SH +: OUT_W];
        end
    end

    assign o_out_valid = r_v5;
    assign o_out_data  = r_s5;

endmodule

### design/battery_current_limit_derating.sv
// ----------------------------------------------------------------------------
// Battery current limit derating: top level
// Path: an accepted input beat is written into the queue, then runs through the back-end stages.
// Throughput: one beat per cycle while the output is not stalled; set by the back-end pipeline (one beat/stage).
// Reset: synchronous, active low; clears queue and valids, capacity to 50000.
// ----------------------------------------------------------------------------
`include "battery_current_limit_derating_defines.svh"

// The block turns one measurement set into a charge and a discharge current
// limit. Six piecewise-linear derating curves are evaluated: temperature,
// state of charge and highest cell voltage bound the charge current, and
// temperature, state of charge and lowest cell voltage bound the discharge
// current. The smallest value of each group, in hundredths of C, is scaled
// by the pack capacity and divided by 100.
//
// The front end finds, for every curve, the segment that holds the clamped
// input and the offset into that segment. That is all compares and small
// subtracts, so it is done in the cycle the beat is accepted and the result
// is written into a four-entry queue. The back end pulls from the queue and
// runs five registered stages:
//   1. slope magnitude times offset,
//   2. exact floor divide by the segment width (reciprocal multiply),
//   3. signed add to the segment start and minimum of each group of three,
//   4. multiply by the capacity,
//   5. divide by 100 (reciprocal multiply); this register drives the output.
// Taking the minimum before scaling gives the same answer as scaling first,
// since the scale is monotonic for any capacity.
//
// Each stage has its own valid bit and moves whenever the stage after it is
// free, so a stall on the output only backs up as far as it must; the queue
// absorbs the rest and keeps o_in_ready up while it has room.
//
// The capacity register is written through its own channel, which is always
// ready. It feeds stage 4 directly and may only be changed while the block
// has no beat in flight.
module battery_current_limit_derating import bcld_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    logic [CAP_W-1:0] r_capacity;

    // Front end to queue.
    logic        fe_wr_valid;
    logic        q_wr_ready;
    t_class_item fe_wr_data;

    // Queue to back end.
    logic        q_rd_valid;
    logic        be_rd_ready;
    t_class_item q_rd_data;
    t_q_stat     q_stat;

    logic        q_push;
    logic        q_pop;

    assign q_push = fe_wr_valid && q_wr_ready;
    assign q_pop  = q_rd_valid && be_rd_ready;

    // Capacity register; the write channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    bcld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_wr_valid (fe_wr_valid),
        .i_wr_ready (q_wr_ready),
        .o_wr_data  (fe_wr_data)
    );

    bcld_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_wr_valid),
        .o_wr_ready (q_wr_ready),
        .i_wr_data  (fe_wr_data),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (be_rd_ready),
        .o_rd_data  (q_rd_data),
        .o_stat     (q_stat)
    );

    bcld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_valid  (q_rd_valid),
        .o_rd_ready  (be_rd_ready),
        .i_rd_data   (q_rd_data),
        .i_capacity  (r_capacity),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The back end only pulls a beat the queue really holds.
    `BCLD_ASSERT(a_pop_not_empty, i_clk, i_rst_n, q_pop |-> (q_stat.count != '0), "pop from empty queue")
    // Queue occupancy follows the push and pop beats.
    `BCLD_ASSERT(a_count_up, i_clk, i_rst_n, (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1), "queue count missed a push")
    `BCLD_ASSERT(a_count_down, i_clk, i_rst_n, (q_pop && !q_push) |=> (q_stat.count == $past(q_stat.count) - 1'b1), "queue count missed a pop")
    // Reset leaves no result beat pending.
    `BCLD_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

### sim/battery_current_limit_derating_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery current limit derating: self-checking testbench
// Drives measurement beats through the block under random idling and
// back-pressure and checks every output beat against a local model of the
// six derating curves, over several pack capacity settings.
// ----------------------------------------------------------------------------
module battery_current_limit_derating_test;
    import bcld_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_AFTER   = 150;     // output beats seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int NUM_PHASES   = 6;

    // Curve identifiers for the local model, charge curves first.
    typedef enum int {
        CRV_TEMP_CHG = 0,
        CRV_SOC_CHG  = 1,
        CRV_CELL_CHG = 2,
        CRV_TEMP_DIS = 3,
        CRV_SOC_DIS  = 4,
        CRV_CELL_DIS = 5
    } t_curve;

    // Breakpoint tables. Entries past a curve's point count are unused.
    localparam int CRV_N [6] = '{8, 5, 3, 15, 9, 7};
    localparam int CRV_X [6][15] = '{
        '{-250, 0, 50, 150, 350, 450, 550, 650, 0, 0, 0, 0, 0, 0, 0},
        '{0, 8500, 9000, 9500, 10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{3000, 4100, 4200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-250, -150, -100, -50, 0, 50, 100, 250, 300, 350, 450, 550, 600, 650, 700},
        '{0, 200, 500, 800, 1000, 1500, 2000, 5000, 10000, 0, 0, 0, 0, 0, 0},
        '{3000, 3200, 3300, 3400, 3450, 3550, 4200, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    localparam int CRV_Y [6][15] = '{
        '{0, 0, 0, 300, 300, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{300, 300, 200, 100, 50, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{300, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{20, 20, 100, 150, 200, 450, 500, 500, 450, 400, 380, 380, 20, 20, 0},
        '{100, 100, 220, 220, 400, 400, 500, 500, 500, 0, 0, 0, 0, 0, 0},
        '{0, 0, 200, 250, 380, 500, 500, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    // Block inputs, all at known values from time zero.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_in_item         i_in_data   = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [CAP_W-1:0] i_cfg_data  = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_out_item        o_out_data;
    logic             o_cfg_ready;

    // Testbench state.
    t_in_item         measurements_pending [$];
    t_out_item        limits_due [$];
    logic [CAP_W-1:0] capacity_now = CAP_RESET;
    bit               beat_taken   = 1'b0;
    bit               send_idle    = 1'b1;
    bit               recv_idle    = 1'b1;
    bit               hold_done    = 1'b0;
    int               hold_left    = 0;
    int               beats_in     = 0;
    int               results_seen = 0;
    int               mismatches   = 0;
    int               cycles       = 0;
    int               capacity_writes = 0;

    battery_current_limit_derating DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Piecewise-linear lookup of one curve, in hundredths of C. Inputs outside
    // the table take the end values; inside, the step truncates toward zero.
    function automatic longint curve_centi_c(input t_curve c, input int x);
        int     n;
        longint dx;
        longint dy;
        longint fr;
        longint r;
        bit     found;
        n     = CRV_N[c];
        r     = CRV_Y[c][n-1];
        found = 1'b0;
        if (x <= CRV_X[c][0]) begin
            return CRV_Y[c][0];
        end
        if (x >= CRV_X[c][n-1]) begin
            return CRV_Y[c][n-1];
        end
        for (int k = 1; k < n; k++) begin
            if (!found && x <= CRV_X[c][k]) begin
                dx    = CRV_X[c][k] - CRV_X[c][k-1];
                dy    = CRV_Y[c][k] - CRV_Y[c][k-1];
                fr    = x - CRV_X[c][k-1];
                r     = CRV_Y[c][k-1] + (dy * fr) / dx;
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic longint scale_to_ma(input longint centi);
        return (centi * longint'(capacity_now)) / 100;
    endfunction

    // Expected charge and discharge limits for one measurement set.
    function automatic t_out_item predict_limits(input t_in_item m);
        int        t;
        int        s;
        int        vh;
        int        vl;
        longint    a;
        longint    b;
        longint    c;
        longint    chg;
        longint    dis;
        t_out_item r;
        t  = $signed(m.max_temp);
        s  = m.charge_level;
        vh = m.high_cell_mv;
        vl = m.low_cell_mv;
        a   = scale_to_ma(curve_centi_c(CRV_TEMP_CHG, t));
        b   = scale_to_ma(curve_centi_c(CRV_SOC_CHG, s));
        c   = scale_to_ma(curve_centi_c(CRV_CELL_CHG, vh));
        chg = (a < b) ? a : b;
        chg = (chg < c) ? chg : c;
        a   = scale_to_ma(curve_centi_c(CRV_TEMP_DIS, t));
        b   = scale_to_ma(curve_centi_c(CRV_SOC_DIS, s));
        c   = scale_to_ma(curve_centi_c(CRV_CELL_DIS, vl));
        dis = (a < b) ? a : b;
        dis = (dis < c) ? dis : c;
        if (chg < 0) begin
            chg = 0;
        end
        if (dis < 0) begin
            dis = 0;
        end
        r.charge_limit_ma    = OUT_W'(chg);
        r.discharge_limit_ma = OUT_W'(dis);
        return r;
    endfunction

    function automatic t_in_item measurement(input int t, input int s, input int vh,
                                             input int vl);
        t_in_item m;
        m.max_temp     = IN_W'(t);
        m.charge_level = IN_W'(s);
        m.high_cell_mv = IN_W'(vh);
        m.low_cell_mv  = IN_W'(vl);
        return m;
    endfunction

    // Mostly realistic readings, often right at or next to a breakpoint, with
    // a share of fully random words so that every input bit toggles.
    function automatic t_in_item random_measurement();
        t_in_item m;
        int       pick;
        int       t;
        int       s;
        int       vh;
        int       vl;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            m = {$urandom, $urandom};
            return m;
        end
        t  = int'($urandom_range(0, 1100)) - 350;
        s  = $urandom_range(0, 11000);
        vh = $urandom_range(2800, 4400);
        vl = $urandom_range(2800, 4400);
        if (pick < 5) begin
            t  = CRV_X[CRV_TEMP_DIS][$urandom_range(0, 14)] + int'($urandom_range(0, 2)) - 1;
            s  = CRV_X[CRV_SOC_DIS][$urandom_range(0, 8)] + int'($urandom_range(0, 2));
            vh = CRV_X[CRV_CELL_CHG][$urandom_range(0, 2)] + int'($urandom_range(0, 2)) - 1;
            vl = CRV_X[CRV_CELL_DIS][$urandom_range(0, 6)] + int'($urandom_range(0, 2)) - 1;
        end
        return measurement(t, s, vh, vl);
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // Input driver: a new beat goes out at the falling edge once the previous
    // one has been taken, with random gaps while idling is enabled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || beat_taken) begin
            if (measurements_pending.size() > 0 &&
                (!send_idle || $urandom_range(0, 99) >= 17)) begin
                i_in_data  <= measurements_pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off once enough beats
    // have come out, so the queue fills and the input side stalls too.
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= recv_idle ? ($urandom_range(0, 99) >= 17) : 1'b1;
        end
    end

    // Monitor: predicts on every accepted input beat and checks every output
    // beat against the oldest prediction, one field at a time.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            beat_taken = 1'b0;
        end else begin
            beat_taken = i_in_valid && o_in_ready;
            if (beat_taken) begin
                limits_due.push_back(predict_limits(i_in_data));
                beats_in++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (limits_due.size() == 0) begin
                    note_mismatch("unexpected output beat", 0, int'(o_out_data.charge_limit_ma));
                end else begin
                    want = limits_due.pop_front();
                    if (o_out_data.charge_limit_ma !== want.charge_limit_ma) begin
                        note_mismatch("charge_limit_ma", int'(want.charge_limit_ma),
                                      int'(o_out_data.charge_limit_ma));
                    end
                    if (o_out_data.discharge_limit_ma !== want.discharge_limit_ma) begin
                        note_mismatch("discharge_limit_ma", int'(want.discharge_limit_ma),
                                      int'(o_out_data.discharge_limit_ma));
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding",
                     cycles, limits_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Hold off the sender until every predicted beat has come out and the
    // pipeline has had time to settle.
    task automatic wait_until_drained();
        while (measurements_pending.size() > 0 || i_in_valid || limits_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Capacity is only written while nothing is in flight.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        capacity_now = value;
        capacity_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] phase_capacity [NUM_PHASES];
        phase_capacity = '{20'd1, 20'hFFFFF, 20'd0, 20'd1000000, 20'd0, 20'd2500};
        phase_capacity[4] = CAP_W'($urandom_range(1, 1000000));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset capacity: field extremes, table end
        // points and just past them, a charge level above full, and points
        // inside segments with rising and falling slopes.
        measurements_pending.push_back(measurement(-32768, 0, 0, 0));
        measurements_pending.push_back(measurement(32767, 65535, 65535, 65535));
        measurements_pending.push_back(measurement(-250, 0, 3000, 3000));
        measurements_pending.push_back(measurement(-251, 8500, 2999, 2999));
        measurements_pending.push_back(measurement(650, 10000, 4200, 4200));
        measurements_pending.push_back(measurement(700, 10001, 4201, 4201));
        measurements_pending.push_back(measurement(701, 65535, 4100, 3550));
        measurements_pending.push_back(measurement(100, 9250, 4150, 3425));
        measurements_pending.push_back(measurement(25, 8750, 4199, 3201));
        measurements_pending.push_back(measurement(425, 9999, 4101, 3500));
        measurements_pending.push_back(measurement(599, 350, 3650, 3275));
        measurements_pending.push_back(measurement(-120, 1250, 4100, 3449));
        measurements_pending.push_back(measurement(675, 3000, 3999, 3550));
        measurements_pending.push_back(measurement(149, 100, 4000, 3301));
        measurements_pending.push_back(measurement(-1, 1, 1, 1));
        measurements_pending.push_back(measurement(500, 650, 4175, 3333));
        measurements_pending.push_back(measurement(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        measurements_pending.push_back(measurement(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        measurements_pending.push_back(measurement(300, 65535, 0, 65535));

        // Random phases, one capacity setting each. The first phase runs
        // into the long output hold-off; one later phase runs with no idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_until_drained();
                write_capacity(phase_capacity[p]);
            end
            send_idle = (p != 3);
            recv_idle = (p != 3);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                measurements_pending.push_back(random_measurement());
            end
        end
        wait_until_drained();

        $display("Covered %0d input beats and %0d output beats over %0d capacity writes,",
                 beats_in, results_seen, capacity_writes);
        $display("including zero and full-scale capacity, a long output hold-off and idle gaps.");
        if (mismatches == 0 && limits_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", mismatches, limits_due.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/bcld_pkg.sv
design/bcld_front.sv
design/bcld_queue.sv
design/bcld_back.sv
design/battery_current_limit_derating.sv
sim/battery_current_limit_derating_test.sv
